// ===== hdl/cau_pkg.sv =====
// shared command and status codes for the complex arithmetic unit
`default_nettype none
package cau_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_EQ  = 3'd4,
        CMD_NE  = 3'd5
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/complex_arithmetic_unit.sv =====
// top level of the complex arithmetic unit
//
// Pipelined complex ALU on signed fixed point operands (Q8.8 by default):
// add, subtract, multiply, divide, equal and not equal. One transfer is
// accepted every cycle unless the queue fills while the result side stalls,
// and each gives exactly one result transfer, in order. A transfer passes the
// front register, which loads on the accepting edge, then the queue, three
// arithmetic stages, DATA_WIDTH restoring divider stages (one quotient bit
// each) and the output register; every command takes the same path so
// results never reorder. A four-entry queue lets the front keep taking
// transfers while the back end is held by the result side. Multiply and
// divide round toward minus infinity; a result that overflows saturates per
// part and reports status 1, division by a zero divisor returns zeros with
// status 2, and unused command codes return all zeros.
`default_nettype none
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    // command, a_re, a_im, b_re, b_im, zero padding
    input  wire logic [((CMD_W+4*DATA_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic       o_m_axis_tvalid,
    input  wire logic  i_m_axis_tready,
    // result_re, result_im, compare_true, status, zero padding
    output logic [((2*DATA_WIDTH+1+STATUS_W+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int W     = DATA_WIDTH;
    localparam int IBITS = CMD_W + 4 * W;
    localparam int OBITS = 2 * W + 1 + STATUS_W;
    localparam int OTW   = ((OBITS + 7) / 8) * 8;
    localparam int QW    = IBITS + 2;

    // front to queue transfer
    logic          f_valid, f_ready;
    logic [QW-1:0] f_data;
    // queue to back transfer
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    // result fields
    logic [W-1:0]          res_re, res_im;
    logic                  res_cmp;
    logic [STATUS_W-1:0]   res_status;

    cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata[IBITS-1:0]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    cau_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_data   (q_data),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_re     (res_re),
        .o_im     (res_im),
        .o_cmp    (res_cmp),
        .o_status (res_status)
    );

    // pack results lowest field first, pad to whole bytes
    assign o_m_axis_tdata = OTW'({res_status, res_cmp, res_im, res_re});

endmodule
`default_nettype wire

// ===== hdl/cau_front.sv =====
// front end: takes input transfers, works out comparisons and the zero divisor flag
`default_nettype none
module cau_front
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [CMD_W+4*DATA_WIDTH-1:0]     i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    // {b_zero, cmp, b_im, b_re, a_im, a_re, command}
    output logic [CMD_W+4*DATA_WIDTH+1:0]          o_data
);
    localparam int W = DATA_WIDTH;

    logic                        r_valid;
    logic [CMD_W+4*W+1:0]        r_data;
    logic [CMD_W-1:0]            cmd;
    logic [W-1:0]                a_re, a_im, b_re, b_im;
    logic                        same;
    logic                        cmp;
    logic                        b_zero;

    assign cmd  = i_data[CMD_W-1:0];
    assign a_re = i_data[CMD_W+:W];
    assign a_im = i_data[CMD_W+W+:W];
    assign b_re = i_data[CMD_W+2*W+:W];
    assign b_im = i_data[CMD_W+3*W+:W];

    always_comb begin
        same   = (a_re == b_re) && (a_im == b_im);
        b_zero = (b_re == '0) && (b_im == '0);
        case (cmd)
            CMD_EQ:  cmp = same;
            CMD_NE:  cmp = !same;
            default: cmp = 1'b0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= {b_zero, cmp, i_data};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cau_fifo.sv =====
// short register queue between front and back end
`default_nettype none
module cau_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cau_back.sv =====
// back end: multiply, combine, round, divide and saturate pipeline
`default_nettype none
module cau_back
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [CMD_W+4*DATA_WIDTH+1:0]     i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [DATA_WIDTH-1:0]                  o_re,
    output logic [DATA_WIDTH-1:0]                  o_im,
    output logic                                   o_cmp,
    output logic [STATUS_W-1:0]                    o_status
);
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int EW = 3 * W + F;

    localparam logic signed [PW-1:0] MAXV = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] MINV = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W:0]           LIM_NEG = {2'b01, {(W-1){1'b0}}};
    localparam logic [W:0]           LIM_POS = {2'b00, {(W-1){1'b1}}};

    typedef struct packed {
        logic                  valid;
        logic [CMD_W-1:0]      cmd;
        logic                  cmp;
        logic                  b_zero;
        logic signed [W:0]     s_re;
        logic signed [W:0]     s_im;
        logic signed [MW-1:0]  p_rr, p_ii, p_ri, p_ir, d_rr, d_ii;
    } t_s1;

    typedef struct packed {
        logic                  valid;
        logic [CMD_W-1:0]      cmd;
        logic                  cmp;
        logic                  b_zero;
        logic signed [W:0]     s_re;
        logic signed [W:0]     s_im;
        logic signed [PW-1:0]  pr;
        logic signed [PW-1:0]  pi;
        logic [MW-1:0]         den;
    } t_s2;

    typedef struct packed {
        logic                  valid;
        logic                  is_div;
        logic [W-1:0]          res_re;
        logic [W-1:0]          res_im;
        logic                  cmp;
        logic [STATUS_W-1:0]   status;
        logic                  neg_re, neg_im;
        logic                  ovf_re, ovf_im;
        logic [EW-1:0]         rem_re, rem_im;
        logic [W-1:0]          q_re, q_im;
        logic [MW-1:0]         den;
    } t_dv;

    typedef struct packed {
        logic                  valid;
        logic [W-1:0]          re;
        logic [W-1:0]          im;
        logic                  cmp;
        logic [STATUS_W-1:0]   status;
    } t_out;

    function automatic logic [W:0] clamp_w(input logic signed [PW-1:0] v);
        logic [W:0] r;
        if (v > MAXV) begin
            r = {1'b1, MAXV[W-1:0]};
        end else if (v < MINV) begin
            r = {1'b1, MINV[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [W:0] div_fin(input logic neg, input logic ovf,
                                           input logic [W-1:0] q, input logic [EW-1:0] rem);
        logic [W:0] mag;
        logic [W:0] r;
        mag = {1'b0, q} + (W+1)'(neg && (rem != '0));
        if (ovf) begin
            r = neg ? {1'b1, MINV[W-1:0]} : {1'b1, MAXV[W-1:0]};
        end else if (neg) begin
            if (mag > LIM_NEG) begin
                r = {1'b1, MINV[W-1:0]};
            end else begin
                r = {1'b0, W'(~mag + 1'b1)};
            end
        end else if (mag > LIM_POS) begin
            r = {1'b1, MAXV[W-1:0]};
        end else begin
            r = {1'b0, mag[W-1:0]};
        end
        return r;
    endfunction

    logic en;
    t_s1  r_s1;
    t_s2  r_s2;
    t_dv  r_s3;
    t_dv  r_dv [W];
    t_out r_out;
    t_s1  n_s1;
    t_s2  n_s2;
    t_dv  n_s3;
    t_out n_out;

    logic [CMD_W-1:0]      in_cmd;
    logic signed [W-1:0]   ar, ai, br, bi;

    // whole pipe moves together, output register frees it
    assign en      = !r_out.valid || i_ready;
    assign o_ready = en;

    assign in_cmd = i_data[CMD_W-1:0];
    assign ar     = i_data[CMD_W+:W];
    assign ai     = i_data[CMD_W+W+:W];
    assign br     = i_data[CMD_W+2*W+:W];
    assign bi     = i_data[CMD_W+3*W+:W];

    // stage one: products and sums
    always_comb begin
        n_s1.valid  = i_valid;
        n_s1.cmd    = in_cmd;
        n_s1.cmp    = i_data[CMD_W+4*W];
        n_s1.b_zero = i_data[CMD_W+4*W+1];
        if (in_cmd == CMD_SUB) begin
            n_s1.s_re = (W+1)'(ar) - (W+1)'(br);
            n_s1.s_im = (W+1)'(ai) - (W+1)'(bi);
        end else begin
            n_s1.s_re = (W+1)'(ar) + (W+1)'(br);
            n_s1.s_im = (W+1)'(ai) + (W+1)'(bi);
        end
        n_s1.p_rr = ar * br;
        n_s1.p_ii = ai * bi;
        n_s1.p_ri = ar * bi;
        n_s1.p_ir = ai * br;
        n_s1.d_rr = br * br;
        n_s1.d_ii = bi * bi;
    end

    // stage two: combine products
    always_comb begin
        n_s2.valid  = r_s1.valid;
        n_s2.cmd    = r_s1.cmd;
        n_s2.cmp    = r_s1.cmp;
        n_s2.b_zero = r_s1.b_zero;
        n_s2.s_re   = r_s1.s_re;
        n_s2.s_im   = r_s1.s_im;
        if (r_s1.cmd == CMD_DIV) begin
            n_s2.pr = PW'(r_s1.p_rr) + PW'(r_s1.p_ii);
            n_s2.pi = PW'(r_s1.p_ir) - PW'(r_s1.p_ri);
        end else begin
            n_s2.pr = PW'(r_s1.p_rr) - PW'(r_s1.p_ii);
            n_s2.pi = PW'(r_s1.p_ri) + PW'(r_s1.p_ir);
        end
        n_s2.den = MW'(r_s1.d_rr) + MW'(r_s1.d_ii);
    end

    // stage three: finish non-divide ops, set up the dividers
    always_comb begin
        logic [W:0]           c_re, c_im;
        logic [MW-1:0]        m_re, m_im;
        logic [EW-1:0]        dtop;
        c_re = '0;
        c_im = '0;
        m_re = MW'(r_s2.pr < 0 ? -r_s2.pr : r_s2.pr);
        m_im = MW'(r_s2.pi < 0 ? -r_s2.pi : r_s2.pi);
        dtop = EW'(r_s2.den) << W;
        n_s3.valid  = r_s2.valid;
        n_s3.is_div = 1'b0;
        n_s3.res_re = '0;
        n_s3.res_im = '0;
        n_s3.cmp    = 1'b0;
        n_s3.status = ST_OK;
        n_s3.neg_re = r_s2.pr < 0;
        n_s3.neg_im = r_s2.pi < 0;
        n_s3.rem_re = EW'(m_re) << F;
        n_s3.rem_im = EW'(m_im) << F;
        n_s3.ovf_re = (EW'(m_re) << F) >= dtop;
        n_s3.ovf_im = (EW'(m_im) << F) >= dtop;
        n_s3.q_re   = '0;
        n_s3.q_im   = '0;
        n_s3.den    = r_s2.den;
        case (r_s2.cmd)
            CMD_ADD, CMD_SUB: begin
                c_re = clamp_w(PW'(r_s2.s_re));
                c_im = clamp_w(PW'(r_s2.s_im));
            end
            CMD_MUL: begin
                c_re = clamp_w(r_s2.pr >>> F);
                c_im = clamp_w(r_s2.pi >>> F);
            end
            CMD_DIV: begin
                if (r_s2.b_zero) begin
                    n_s3.status = ST_DIV0;
                end else begin
                    n_s3.is_div = 1'b1;
                end
            end
            CMD_EQ, CMD_NE: begin
                n_s3.cmp = r_s2.cmp;
            end
            default: begin
            end
        endcase
        n_s3.res_re = c_re[W-1:0];
        n_s3.res_im = c_im[W-1:0];
        if (c_re[W] || c_im[W]) begin
            n_s3.status = ST_SAT;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar i = 0; i < W; i++) begin : g_div
        t_dv prev;
        t_dv n_dv;
        if (i == 0) begin : g_first
            assign prev = r_s3;
        end else begin : g_rest
            assign prev = r_dv[i-1];
        end
        always_comb begin
            logic [EW-1:0] dsh;
            dsh  = EW'(prev.den) << (W - 1 - i);
            n_dv = prev;
            if (prev.rem_re >= dsh) begin
                n_dv.rem_re           = prev.rem_re - dsh;
                n_dv.q_re[W - 1 - i]  = 1'b1;
            end
            if (prev.rem_im >= dsh) begin
                n_dv.rem_im           = prev.rem_im - dsh;
                n_dv.q_im[W - 1 - i]  = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i].valid <= 1'b0;
            end else if (en) begin
                r_dv[i] <= n_dv;
            end
        end
    end

    // final stage: rounding correction and saturation of quotients, other results pass through
    always_comb begin
        t_dv        t;
        logic [W:0] f_re, f_im;
        t    = r_dv[W-1];
        f_re = div_fin(t.neg_re, t.ovf_re, t.q_re, t.rem_re);
        f_im = div_fin(t.neg_im, t.ovf_im, t.q_im, t.rem_im);
        n_out.valid = t.valid;
        if (t.is_div) begin
            n_out.re     = f_re[W-1:0];
            n_out.im     = f_im[W-1:0];
            n_out.cmp    = 1'b0;
            n_out.status = (f_re[W] || f_im[W]) ? ST_SAT : ST_OK;
        end else begin
            n_out.re     = t.res_re;
            n_out.im     = t.res_im;
            n_out.cmp    = t.cmp;
            n_out.status = t.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_s3.valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out.valid;
    assign o_re     = r_out.re;
    assign o_im     = r_out.im;
    assign o_cmp    = r_out.cmp;
    assign o_status = r_out.status;

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.status == ST_DIV0 |-> r_out.re == '0 && r_out.im == '0)
        else $error("divide by zero result not cleared");
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.cmp |-> r_out.status == ST_OK && r_out.re == '0
        && r_out.im == '0)
        else $error("comparison result carries arithmetic data");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid |-> r_out.status != 2'd3)
        else $error("undefined status code");
    // bubbles may carry unknown data, so compare bit for bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_s3 === $past(r_s3)) && (r_dv[W-1] === $past(r_dv[W-1])))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== tb/tb_complex_arithmetic_unit.sv =====
// testbench for the complex arithmetic unit: directed and random operations checked in order
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int DW     = 16;
    localparam int FB     = 8;
    localparam int IN_W   = ((CMD_W + 4*DW + 7)/8)*8;
    localparam int OUT_W  = ((2*DW + 1 + STATUS_W + 7)/8)*8;
    localparam int LAT    = DW + 6;

    typedef struct packed {
        logic [DW-1:0]       re;
        logic [DW-1:0]       im;
        logic                cmp;
        logic [STATUS_W-1:0] st;
    } t_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;

    t_res  expected_q[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_got = 0;
    int    n_sat = 0;
    int    n_div0 = 0;
    bit    rx_enable = 1'b0;

    always #5 i_clk = ~i_clk;

    complex_arithmetic_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // command, a_re, a_im, b_re, b_im, zero padding
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // result_re, result_im, compare_true, status, zero padding
        .o_m_axis_tdata  (m_data)
    );

    // clamp a wide signed value to the data range, flag saturation
    function automatic logic [DW-1:0] clamp_part(input logic signed [79:0] v, inout bit sat);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        hi = (80'sd1 <<< (DW-1)) - 1;
        lo = -(80'sd1 <<< (DW-1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // floor(n * 2^FB / d) for d > 0
    function automatic logic signed [79:0] floor_quot(input logic signed [79:0] n,
                                                      input logic signed [79:0] d);
        logic signed [79:0] num;
        logic signed [79:0] q;
        num = n <<< FB;
        q = num / d;
        if ((num % d != 0) && (num < 0))
            q = q - 1;
        return q;
    endfunction

    function automatic t_res predict_result(input t_cmd cmd,
                                            input logic signed [DW-1:0] ar,
                                            input logic signed [DW-1:0] ai,
                                            input logic signed [DW-1:0] br,
                                            input logic signed [DW-1:0] bi);
        t_res r;
        bit sat;
        logic signed [79:0] pr;
        logic signed [79:0] pi;
        logic signed [79:0] den;
        r = '0;
        sat = 1'b0;
        case (cmd)
            CMD_ADD: begin
                r.re = clamp_part(80'(ar) + 80'(br), sat);
                r.im = clamp_part(80'(ai) + 80'(bi), sat);
            end
            CMD_SUB: begin
                r.re = clamp_part(80'(ar) - 80'(br), sat);
                r.im = clamp_part(80'(ai) - 80'(bi), sat);
            end
            CMD_MUL: begin
                pr = 80'(ar) * 80'(br) - 80'(ai) * 80'(bi);
                pi = 80'(ar) * 80'(bi) + 80'(ai) * 80'(br);
                r.re = clamp_part(pr >>> FB, sat);
                r.im = clamp_part(pi >>> FB, sat);
            end
            CMD_DIV: begin
                den = 80'(br) * 80'(br) + 80'(bi) * 80'(bi);
                if (den == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    pr = 80'(ar) * 80'(br) + 80'(ai) * 80'(bi);
                    pi = 80'(ai) * 80'(br) - 80'(ar) * 80'(bi);
                    r.re = clamp_part(floor_quot(pr, den), sat);
                    r.im = clamp_part(floor_quot(pi, den), sat);
                end
            end
            CMD_EQ:  r.cmp = (ar == br) && (ai == bi);
            CMD_NE:  r.cmp = (ar != br) || (ai != bi);
            default: ;
        endcase
        if (sat)
            r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("ERROR result %0d: %s got %0h expected %0h", n_got, what, got, want);
    endtask

    // drive one operation and wait for its transfer, valid stays up when no gap follows
    task automatic send_op(input logic [2:0] cmd, input logic [DW-1:0] ar,
                           input logic [DW-1:0] ai, input logic [DW-1:0] br,
                           input logic [DW-1:0] bi);
        t_res want;
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        want = predict_result(t_cmd'(cmd), ar, ai, br, bi);
        s_valid <= 1'b1;
        s_data <= IN_W'({bi, br, ai, ar, cmd});
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        expected_q.push_back(want);
        n_sent++;
        if (want.st == ST_SAT)
            n_sat++;
        if (want.st == ST_DIV0)
            n_div0++;
        @(negedge i_clk);
    endtask

    // result side: random stalls, in-order comparison
    initial begin
        int stall;
        t_res got;
        t_res want;
        forever begin
            @(negedge i_clk);
            if (!rx_enable) begin
                m_ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                m_ready <= 1'b1;
                @(posedge i_clk);
                while (!m_valid)
                    @(posedge i_clk);
                got = m_data[2*DW+1+STATUS_W-1:0];
                got = {m_data[DW-1:0], m_data[2*DW-1:DW], m_data[2*DW],
                       m_data[2*DW+STATUS_W:2*DW+1]};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("ERROR unexpected result transfer %0d", n_got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.re !== want.re)  report_mismatch("result_re", got.re, want.re);
                    if (got.im !== want.im)  report_mismatch("result_im", got.im, want.im);
                    if (got.cmp !== want.cmp) report_mismatch("compare_true", got.cmp, want.cmp);
                    if (got.st !== want.st)  report_mismatch("status", got.st, want.st);
                end
                n_got++;
            end
        end
    end

    function automatic logic [DW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return DW'($signed($urandom_range(0, 1024)) - 512);
            3:       return DW'($signed($urandom_range(0, 8192)) - 4096);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_op(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);   // both parts saturate
        send_op(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        send_op(CMD_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
        send_op(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0000);   // negate most negative
        send_op(CMD_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
        send_op(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);   // floor of tiny negative
        send_op(CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_op(CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);   // division by zero
        send_op(CMD_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_op(CMD_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
        send_op(CMD_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000);   // negative rounding
        send_op(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);   // huge quotient
        send_op(CMD_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
        send_op(CMD_DIV, 16'h0200, 16'h0300, 16'h8000, 16'h8000);
        send_op(CMD_EQ,  16'h1234, 16'h5678, 16'h1234, 16'h5678);
        send_op(CMD_EQ,  16'h1234, 16'h5678, 16'h1234, 16'h5679);
        send_op(CMD_NE,  16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_op(CMD_NE,  16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_op(3'd6,    16'hffff, 16'hffff, 16'hffff, 16'hffff);   // unused codes
        send_op(3'd7,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(input int count);
        logic [2:0] cmd;
        logic [DW-1:0] ar, ai, br, bi;
        for (int k = 0; k < count; k++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            ar = rand_operand();
            ai = rand_operand();
            br = rand_operand();
            bi = rand_operand();
            if ((cmd == CMD_EQ || cmd == CMD_NE) && $urandom_range(0, 1)) begin
                br = ar;
                bi = ai;
            end
            if (cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(cmd, ar, ai, br, bi);
        end
    endtask

    // sender holds off until the pipeline has drained
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        test_random(50);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(700);
        test_drain_pause();
        test_random(780);
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (LAT + 10) @(negedge i_clk);
        $display("sent %0d operations, checked %0d results", n_sent, n_got);
        $display("saturating cases %0d, division by zero cases %0d", n_sat, n_div0);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_complex_arithmetic_unit OK");
        end else begin
            $display("tb_complex_arithmetic_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_complex_arithmetic_unit NOT OK");
        $finish;
    end

endmodule
